// ===== hdl/activity_hysteresis_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the activity hysteresis counter
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACTIVITY_HYSTERESIS_COUNTER_MACROS_SVH
`define ACTIVITY_HYSTERESIS_COUNTER_MACROS_SVH

// plain clocked property
`define AHC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define AHC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    `AHC_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define AHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    `AHC_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/ahc_pkg.sv =====
// ----------------------------------------------------------------------------
// ahc_pkg
// Types and constants shared by the activity hysteresis counter modules.
// ----------------------------------------------------------------------------
package ahc_pkg;

    localparam int PROBS     = 8;
    localparam int PROB_W    = 16;
    localparam int CLS_W     = 3;
    localparam int CNT_W     = 16;
    localparam int TOTAL_W   = 32;
    localparam int CD_W      = 4;
    localparam int IN_DATA_W = 160;
    localparam int OUT_DATA_W = 56;

    // operation codes
    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_RESET    = 2'd1;
    localparam logic [1:0] OP_SUMMARY  = 2'd2;

    // event codes
    localparam logic [2:0] EV_NOTHING   = 3'd0;
    localparam logic [2:0] EV_START     = 3'd1;
    localparam logic [2:0] EV_REP       = 3'd2;
    localparam logic [2:0] EV_RUN_END   = 3'd3;
    localparam logic [2:0] EV_RESET     = 3'd4;
    localparam logic [2:0] EV_SUM_COUNT = 3'd5;
    localparam logic [2:0] EV_SUM_TOTAL = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_START_TH = 3'd0;
    localparam logic [2:0] CFG_END_TH   = 3'd1;
    localparam logic [2:0] CFG_CD_WIN   = 3'd2;
    localparam logic [2:0] CFG_IDLE     = 3'd3;
    localparam logic [2:0] CFG_RUN      = 3'd4;

    localparam logic [PROB_W-1:0] START_TH_RST = 16'd58982;
    localparam logic [PROB_W-1:0] END_TH_RST   = 16'd26214;
    localparam logic [CD_W-1:0]   CD_WIN_RST   = 4'd3;
    localparam logic [CLS_W-1:0]  IDLE_RST     = 3'd0;
    localparam logic [CLS_W-1:0]  RUN_RST      = 3'd1;

    // ms -> s: x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam int PROD_W    = 61;
    localparam int DIV_SHIFT = 38;
    localparam logic [28:0] DIV_MAGIC = 29'd274877907;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_UPD,
        S_RST,
        S_SREAD,
        S_SEMIT,
        S_STOT
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_START,
        K_END_RUN,
        K_END_REP
    } t_kind;

    typedef struct packed {
        logic              found;
        logic [CLS_W-1:0]  idx;
        logic [PROB_W-1:0] prob;
    } t_best;

endpackage

// ===== hdl/ahc_argmax.sv =====
// ----------------------------------------------------------------------------
// ahc_argmax
// Registered strict argmax over the class probabilities; lowest index wins
// a tie, nothing is found when every probability is zero.
// ----------------------------------------------------------------------------
module ahc_argmax #(
    parameter int CLASSES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic [CLASSES-1:0][ahc_pkg::PROB_W-1:0] i_prob,
    output ahc_pkg::t_best                         o_best
);
    import ahc_pkg::*;

    t_best best_c;
    t_best r_best;

    always_comb begin
        best_c = '0;
        for (int c = 0; c < CLASSES; c++) begin
            if (i_prob[c] > best_c.prob) begin
                best_c.prob  = i_prob[c];
                best_c.idx   = CLS_W'(c);
                best_c.found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_best <= best_c;
        end
    end

    assign o_best = r_best;

endmodule

// ===== hdl/activity_hysteresis_counter.sv =====
// ----------------------------------------------------------------------------
// activity_hysteresis_counter
// Exercise start/end hysteresis with cooldown, per-class repetition counts
// held in a small synchronous memory, and a timed run total.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser = operation, tdata = the
//   class probabilities and the millisecond timestamp. m_axis returns the
//   event beats; tlast marks the final beat of a command.
//   One command is in work at a time; s_axis_tready is high only while the
//   sequencer waits for a command.
//   Classification: after the accept the sequencer steps through the count
//   read, the ms-to-s multiply, and the update and write-back that loads the
//   output register, then takes the next command. Reset command: a clearing
//   step that emits the reset beat. Summary: a read step and an emit step per
//   reported class (one count memory read each), a read step per skipped
//   class, then a step for the total. Operation 3 is dropped at accept with no beat.
//   The output register holds a beat until m_axis_tready; the sequencer
//   stalls in its emitting step meanwhile and resumes when the slot frees.
//   Reset (i_rst_n low at a clock edge) loads the register defaults and
//   clears the exercise state and run total; count valid bits are cleared
//   at once, so no clearing pass is needed.
//   Configuration writes through i_cfg_* apply at once; write them only
//   while no command is in work.
// ----------------------------------------------------------------------------
`include "activity_hysteresis_counter_macros.svh"

module activity_hysteresis_counter #(
    parameter int CLASSES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_idx,
    input  logic [15:0]                        i_cfg_data,
    // commands
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // prob_0 .. prob_7 (16 b each), now_ms (32 b)
    input  logic [ahc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation (2 b)
    input  logic [1:0]                         s_axis_tuser,
    // events
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // class_index (3 b), count (16 b), run_seconds (32 b), exercising (1 b), pad
    output logic [ahc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // event_res (3 b)
    output logic [2:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import ahc_pkg::*;

    localparam int AW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CW = $clog2(CLASSES + 1);

    // config registers
    logic [PROB_W-1:0] r_start_th, r_end_th;
    logic [CD_W-1:0]   r_cd_win;
    logic [CLS_W-1:0]  r_idle, r_run;

    // sequencer and state
    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic                 r_active, n_active;
    logic [AW-1:0]        r_aidx, n_aidx;
    logic [CD_W-1:0]      r_cd, n_cd;
    logic [TOTAL_W-1:0]   r_run_start, n_run_start;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [CW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_cls, n_cls;
    logic [TOTAL_W-1:0]   r_diff, n_diff;
    logic [PROD_W-1:0]    r_prod, n_prod;

    // captured command
    logic [CLASSES-1:0][PROB_W-1:0] r_prob;
    logic [CLASSES-1:0][PROB_W-1:0] in_prob;
    logic [TOTAL_W-1:0]             r_now;
    t_best                          best;

    // count memory
    logic [CNT_W-1:0]   r_mem [CLASSES];
    logic [CLASSES-1:0] r_vld, n_vld;
    logic [CNT_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic               rd_en, mem_we;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CNT_W-1:0]   wr_data;

    // output register
    logic               r_ov;
    logic [2:0]         r_o_ev, n_o_ev;
    logic [CLS_W-1:0]   r_o_cls, n_o_cls;
    logic [CNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [TOTAL_W-1:0] r_o_total, n_o_total;
    logic               r_o_exer, n_o_exer;
    logic               r_o_last, n_o_last;

    logic               accept, slot_free, push;
    logic [CD_W-1:0]    cd_dec;
    logic [CNT_W-1:0]   rd_cnt, cnt_inc;
    logic [CLS_W-1:0]   idx_cls;
    logic               idx_skip, idx_done;

    always_comb begin
        for (int c = 0; c < CLASSES; c++) begin
            in_prob[c] = s_axis_tdata[c*PROB_W +: PROB_W];
        end
    end

    ahc_argmax #(
        .CLASSES (CLASSES)
    ) u_argmax (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_prob (in_prob),
        .o_best (best)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_ov || m_axis_tready;

    assign cd_dec   = (r_cd != '0) ? r_cd - 1'b1 : r_cd;
    assign rd_cnt   = r_rd_vld ? r_rd_data : '0;
    assign cnt_inc  = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    assign idx_cls  = CLS_W'(r_idx);
    assign idx_done = (r_idx == CW'(CLASSES));
    assign idx_skip = (idx_cls == r_idle) || (idx_cls == r_run);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        OP_CLASSIFY: n_state = S_EVAL;
                        OP_RESET:    n_state = S_RST;
                        OP_SUMMARY:  n_state = S_SREAD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_EVAL:  n_state = S_MUL;
            S_MUL:   n_state = S_UPD;
            S_UPD:   n_state = slot_free ? S_IDLE : S_UPD;
            S_RST:   n_state = slot_free ? S_IDLE : S_RST;
            S_SREAD: begin
                if (idx_done) begin
                    n_state = S_STOT;
                end else if (!idx_skip) begin
                    n_state = S_SEMIT;
                end
            end
            S_SEMIT: n_state = slot_free ? S_SREAD : S_SEMIT;
            S_STOT:  n_state = slot_free ? S_IDLE : S_STOT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_kind      = r_kind;
        n_active    = r_active;
        n_aidx      = r_aidx;
        n_cd        = r_cd;
        n_run_start = r_run_start;
        n_total     = r_total;
        n_idx       = r_idx;
        n_cls       = r_cls;
        n_diff      = r_now - r_run_start;
        n_prod      = PROD_W'(r_diff) * PROD_W'(DIV_MAGIC);
        n_vld       = r_vld;
        rd_en       = 1'b0;
        rd_addr     = r_aidx;
        mem_we      = 1'b0;
        wr_addr     = r_cls;
        wr_data     = cnt_inc;
        push        = 1'b0;
        n_o_ev      = EV_NOTHING;
        n_o_cls     = '0;
        n_o_cnt     = '0;
        n_o_total   = r_total;
        n_o_exer    = r_active;
        n_o_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                end
            end
            S_EVAL: begin
                n_cd = cd_dec;
                rd_en = 1'b1;
                if (!r_active) begin
                    n_cls   = best.idx[AW-1:0];
                    rd_addr = best.idx[AW-1:0];
                    if (best.found && (best.prob > r_start_th) && (best.idx != r_idle)
                            && (cd_dec == '0)) begin
                        n_kind = K_START;
                    end else begin
                        n_kind = K_NONE;
                    end
                end else begin
                    n_cls = r_aidx;
                    if (r_prob[r_aidx] < r_end_th) begin
                        n_kind = (CLS_W'(r_aidx) == r_run) ? K_END_RUN : K_END_REP;
                    end else begin
                        n_kind = K_NONE;
                    end
                end
            end
            S_UPD: begin
                if (slot_free) begin
                    push = 1'b1;
                    case (r_kind)
                        K_START: begin
                            n_active = 1'b1;
                            n_aidx   = r_cls;
                            if (CLS_W'(r_cls) == r_run) begin
                                n_run_start = r_now;
                            end
                            n_o_ev  = EV_START;
                            n_o_cls = CLS_W'(r_cls);
                            n_o_cnt = rd_cnt;
                        end
                        K_END_RUN: begin
                            n_active = 1'b0;
                            n_cd     = r_cd_win;
                            n_total  = r_total
                                     + TOTAL_W'(r_prod[PROD_W-1:DIV_SHIFT]);
                            n_o_ev   = EV_RUN_END;
                            n_o_cls  = CLS_W'(r_cls);
                        end
                        K_END_REP: begin
                            n_active = 1'b0;
                            n_cd     = r_cd_win;
                            mem_we   = 1'b1;
                            n_vld[r_cls] = 1'b1;
                            n_o_ev   = EV_REP;
                            n_o_cls  = CLS_W'(r_cls);
                            n_o_cnt  = cnt_inc;
                        end
                        default: begin
                            n_o_ev = EV_NOTHING;
                        end
                    endcase
                    n_o_total = n_total;
                    n_o_exer  = n_active;
                end
            end
            S_RST: begin
                if (slot_free) begin
                    push      = 1'b1;
                    n_vld     = '0;
                    n_total   = '0;
                    n_active  = 1'b0;
                    n_cd      = '0;
                    n_o_ev    = EV_RESET;
                    n_o_total = '0;
                    n_o_exer  = 1'b0;
                end
            end
            S_SREAD: begin
                if (!idx_done) begin
                    if (idx_skip) begin
                        n_idx = CW'(r_idx + 1'b1);
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx[AW-1:0];
                    end
                end
            end
            S_SEMIT: begin
                if (slot_free) begin
                    push     = 1'b1;
                    n_idx    = CW'(r_idx + 1'b1);
                    n_o_ev   = EV_SUM_COUNT;
                    n_o_cls  = idx_cls;
                    n_o_cnt  = rd_cnt;
                    n_o_last = 1'b0;
                end
            end
            S_STOT: begin
                if (slot_free) begin
                    push   = 1'b1;
                    n_o_ev = EV_SUM_TOTAL;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_NONE;
            r_active    <= 1'b0;
            r_aidx      <= '0;
            r_cd        <= '0;
            r_run_start <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_vld       <= '0;
            r_ov        <= 1'b0;
            r_start_th  <= START_TH_RST;
            r_end_th    <= END_TH_RST;
            r_cd_win    <= CD_WIN_RST;
            r_idle      <= IDLE_RST;
            r_run       <= RUN_RST;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_active    <= n_active;
            r_aidx      <= n_aidx;
            r_cd        <= n_cd;
            r_run_start <= n_run_start;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_vld       <= n_vld;
            if (push) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_TH: r_start_th <= i_cfg_data;
                    CFG_END_TH:   r_end_th   <= i_cfg_data;
                    CFG_CD_WIN:   r_cd_win   <= i_cfg_data[CD_W-1:0];
                    CFG_IDLE:     r_idle     <= i_cfg_data[CLS_W-1:0];
                    CFG_RUN:      r_run      <= i_cfg_data[CLS_W-1:0];
                    default:      r_run      <= r_run;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prob <= in_prob;
            r_now  <= s_axis_tdata[PROBS*PROB_W +: TOTAL_W];
        end
        r_cls  <= n_cls;
        r_diff <= n_diff;
        r_prod <= n_prod;
        if (push) begin
            r_o_ev    <= n_o_ev;
            r_o_cls   <= n_o_cls;
            r_o_cnt   <= n_o_cnt;
            r_o_total <= n_o_total;
            r_o_exer  <= n_o_exer;
            r_o_last  <= n_o_last;
        end
    end

    // count memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_ev;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {4'b0000, r_o_exer, r_o_total, r_o_cnt, r_o_cls};

    `AHC_ASSERT_CLK(a_no_rw_overlap, !(mem_we && rd_en), "count memory read and write collide")
    `AHC_ASSERT_IMPLY(a_no_overwrite, r_ov && !m_axis_tready, !push, "pending beat overwritten")
    `AHC_ASSERT_NEXT(a_reset_clears, push && (r_state == S_RST), (r_vld == '0) && !r_active && (r_total == '0), "reset command left state")
    `AHC_ASSERT_IMPLY(a_start_exer, push && (n_o_ev == EV_START), n_o_exer && n_o_last, "start beat without exercise")

endmodule
